/* src/assert_macros.svh */
// assertion macros shared by the frame bitmap allocator modules
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define FBA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fba assertion failed");

// antecedent this cycle implies consequent in the next cycle
`define FBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fba assertion failed");

`endif

/* src/fba_pkg.sv */
// types and constants of the frame bitmap allocator
// no dependencies; used by the controller, the datapath and the top level
package fba_pkg;

   localparam int WORD_BITS = 32;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_MAPPED  = 2'd1;
   localparam logic [1:0] STATUS_NO_FREE = 2'd2;
   localparam logic [1:0] STATUS_RANGE   = 2'd3;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_MAP   = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] phys_address;
      logic [19:0] entry_frame;
      logic        kernel_page;
      logic        writable_page;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] frame_number;
      logic        present_bit;
      logic        write_bit;
      logic        user_bit;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       scan_rd;
      logic       map_rd;
      logic       clr_wr;
      logic       upd_wr;
      logic       rsp_send;
      logic [1:0] rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic entry_mapped;
      logic is_map;
      logic map_oor;
      logic rd_valid;
      logic word_full;
      logic word_last;
      logic alloc_oor;
      logic scan_done;
      logic clr_last;
   } sts_type;

endpackage

/* src/fba_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies; holds the used-frame bitmap
module fba_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 128,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fba_datapath.sv */
// datapath of the frame bitmap allocator: request register, bitmap ram,
// scan and clear counters, lowest-free search and result register; uses fba_pkg, fba_ram
module fba_datapath #(
   parameter int NUM_FRAMES  = 4096,
   parameter int FRAME_BYTES = 4096,
   parameter int WORD_COUNT  = (NUM_FRAMES + 31) / 32,
   parameter int ADDR_BITS   = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  fba_pkg::req_type req_data,
   input  fba_pkg::cmd_type cmd,
   output fba_pkg::sts_type sts,
   output logic             rsp_strobe,
   output fba_pkg::rsp_type rsp_data
);

   localparam int FB_SHIFT   = $clog2(FRAME_BYTES);
   localparam int FRAME_BITS = ADDR_BITS + 5;

   function automatic logic [4:0] bit_index(input logic [31:0] onehot);
      logic [4:0] idx;
      idx = '0;
      for (int j = 0; j < 32; j++) begin
         if (onehot[j]) begin
            idx = idx | 5'(j);
         end
      end
      return idx;
   endfunction

   fba_pkg::req_type       req_ff;
   logic [ADDR_BITS:0]     scan_ff, scan_in;
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;
   logic                   chk_valid_ff;
   logic [ADDR_BITS-1:0]   chk_addr_ff;
   logic                   rsp_valid_ff;
   fba_pkg::rsp_type       rsp_ff, rsp_in;

   logic [32:0]            map_full_frame;
   logic [FRAME_BITS-1:0]  map_frame;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic                   rd_en;
   logic [31:0]            rd_word;
   logic [31:0]            low_zero;
   logic [FRAME_BITS-1:0]  found_frame;
   logic [FRAME_BITS-1:0]  sel_frame;
   logic [31:0]            wr_word;
   logic [ADDR_BITS-1:0]   wr_addr;

   // frame of the mapped address, kept wide for the range check
   assign map_full_frame = {1'b0, req_ff.phys_address} >> FB_SHIFT;
   assign map_frame      = map_full_frame[FRAME_BITS-1:0];

   assign rd_en   = cmd.scan_rd | cmd.map_rd;
   assign rd_addr = cmd.scan_rd ? scan_ff[ADDR_BITS-1:0] : map_frame[FRAME_BITS-1:5];

   // isolate the lowest clear bit
   assign low_zero    = ~rd_word & (rd_word + 32'd1);
   assign found_frame = {chk_addr_ff, bit_index(low_zero)};
   assign sel_frame   = req_ff.kind == fba_pkg::KIND_MAP ? map_frame : found_frame;

   assign wr_word = req_ff.kind == fba_pkg::KIND_MAP
                    ? (rd_word | (32'd1 << map_frame[4:0]))
                    : (rd_word | low_zero);
   assign wr_addr = cmd.clr_wr ? clr_ff : chk_addr_ff;

   fba_ram #(
      .WIDTH     (fba_pkg::WORD_BITS),
      .DEPTH     (WORD_COUNT),
      .ADDR_BITS (ADDR_BITS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (cmd.clr_wr | cmd.upd_wr),
      .wr_addr (wr_addr),
      .wr_data (cmd.clr_wr ? 32'd0 : wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   always_comb begin
      scan_in = scan_ff;
      if (cmd.load_req) begin
         scan_in = '0;
      end else if (cmd.scan_rd) begin
         scan_in = scan_ff + 1'b1;
      end
      clr_in = cmd.clr_wr ? clr_ff + 1'b1 : clr_ff;

      rsp_in              = rsp_ff;
      rsp_in.status       = cmd.rsp_status;
      rsp_in.frame_number = cmd.rsp_status == fba_pkg::STATUS_DONE ? 12'(sel_frame) : 12'd0;
      rsp_in.present_bit  = cmd.rsp_status == fba_pkg::STATUS_DONE;
      rsp_in.write_bit    = req_ff.writable_page;
      rsp_in.user_bit     = ~req_ff.kernel_page;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         clr_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         clr_ff       <= clr_in;
         chk_valid_ff <= rd_en;
         rsp_valid_ff <= cmd.rsp_send;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (rd_en) begin
         chk_addr_ff <= rd_addr;
      end
      if (cmd.rsp_send) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      sts.entry_mapped = req_ff.entry_frame != 20'd0;
      sts.is_map       = req_ff.kind == fba_pkg::KIND_MAP;
      sts.map_oor      = map_full_frame >= 33'(NUM_FRAMES);
      sts.rd_valid     = chk_valid_ff;
      sts.word_full    = rd_word == 32'hFFFF_FFFF;
      sts.word_last    = chk_addr_ff == ADDR_BITS'(WORD_COUNT - 1);
      sts.alloc_oor    = (FRAME_BITS + 1)'(found_frame) >= (FRAME_BITS + 1)'(NUM_FRAMES);
      sts.scan_done    = scan_ff == (ADDR_BITS + 1)'(WORD_COUNT);
      sts.clr_last     = clr_ff == ADDR_BITS'(WORD_COUNT - 1);
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* src/fba_ctrl.sv */
// controller of the frame bitmap allocator: clear pass, decode, scan and map sequencing
// uses fba_pkg and assert_macros.svh; drives fba_datapath by command signals
module fba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fba_pkg::sts_type sts,
   output fba_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_MAP    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       item_finish;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.entry_mapped) begin
               cmd.rsp_send   = 1'b1;
               cmd.rsp_status = fba_pkg::STATUS_MAPPED;
               state_in       = ST_IDLE;
            end else if (sts.is_map) begin
               if (sts.map_oor) begin
                  cmd.rsp_send   = 1'b1;
                  cmd.rsp_status = fba_pkg::STATUS_RANGE;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.map_rd = 1'b1;
                  state_in   = ST_MAP;
               end
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.rd_valid && !sts.word_full && !sts.alloc_oor) begin
               cmd.upd_wr     = 1'b1;
               cmd.rsp_send   = 1'b1;
               cmd.rsp_status = fba_pkg::STATUS_DONE;
               state_in       = ST_IDLE;
            end else if (sts.rd_valid && (sts.alloc_oor || sts.word_last)) begin
               cmd.rsp_send   = 1'b1;
               cmd.rsp_status = fba_pkg::STATUS_NO_FREE;
               state_in       = ST_IDLE;
            end else if (!sts.scan_done) begin
               cmd.scan_rd = 1'b1;
            end
         end
         ST_MAP: begin
            if (sts.rd_valid) begin
               cmd.upd_wr     = 1'b1;
               cmd.rsp_send   = 1'b1;
               cmd.rsp_status = fba_pkg::STATUS_DONE;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

   // a transaction going back to idle
   assign item_finish = state_ff != ST_IDLE && state_ff != ST_CLEAR && state_in == ST_IDLE;

`include "assert_macros.svh"

   `FBA_ASSERT(a_upd_needs_data, clock, reset, cmd.upd_wr |-> sts.rd_valid)
   `FBA_ASSERT(a_scan_in_bounds, clock, reset, cmd.scan_rd |-> !sts.scan_done)
   `FBA_ASSERT(a_idle_with_result, clock, reset, item_finish |-> cmd.rsp_send)

endmodule

/* src/frame_bitmap_allocator.sv */
// results: a mapped entry or an out-of-range map is answered from the decide state, a map
// from the map state after its word read, an allocate once the scan reaches the first
// bitmap word with a free frame; one transaction at a time, the next one is accepted once
// busy falls, as the last result shows; a full allocation scan reads one ram word per cycle
// reset: synchronous, active high; then a clearing pass writes WORD_COUNT words
// with busy high; results cannot be stalled and show for one cycle on rsp_strobe
module frame_bitmap_allocator #(
   parameter int NUM_FRAMES  = 4096,
   parameter int FRAME_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fba_pkg::req_type req_data,
   output logic             rsp_strobe,
   output fba_pkg::rsp_type rsp_data
);

   // one bitmap word per 32 frames, spare bits of the last word stay unused
   localparam int WORD_COUNT = (NUM_FRAMES + 31) / 32;
   localparam int ADDR_BITS  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   // command and status groups between controller and datapath
   fba_pkg::cmd_type cmd;
   fba_pkg::sts_type sts;

   // sequencer: clear pass, decode, word scan, map read-modify-write
   fba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // bitmap ram, lowest-free search and the result register
   fba_datapath #(
      .NUM_FRAMES  (NUM_FRAMES),
      .FRAME_BYTES (FRAME_BYTES),
      .WORD_COUNT  (WORD_COUNT),
      .ADDR_BITS   (ADDR_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`include "assert_macros.svh"

   // an accepted transaction always makes the block busy in the following cycle
   `FBA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // each result shows for a single cycle
   `FBA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

endmodule

/* dv/frame_bitmap_allocator_checker.sv */
`timescale 1ns / 100ps
// result checker for the frame bitmap allocator: keeps its own used-frame bitmap,
// predicts every page entry result and compares it field by field; depends on fba_pkg
module frame_bitmap_allocator_checker #(
   parameter int NUM_FRAMES  = 4096,
   parameter int FRAME_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  fba_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  fba_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               entries_in_flight,
   output int               frames_free
);

   localparam int WORD_COUNT = (NUM_FRAMES + fba_pkg::WORD_BITS - 1) / fba_pkg::WORD_BITS;

   // shadow bitmap, cleared while reset is high
   logic [fba_pkg::WORD_BITS-1:0] used_words [WORD_COUNT];
   int                            used_total;
   fba_pkg::rsp_type              entry_results_q [$];

   function automatic void claim_frame(input int unsigned frame);
      if (!used_words[frame / fba_pkg::WORD_BITS][frame % fba_pkg::WORD_BITS]) begin
         used_words[frame / fba_pkg::WORD_BITS][frame % fba_pkg::WORD_BITS] = 1'b1;
         used_total++;
      end
   endfunction

   // first-fit allocate or map, updating the shadow bitmap
   function automatic fba_pkg::rsp_type predict_page_entry(input fba_pkg::req_type entry);
      fba_pkg::rsp_type res;
      logic [1:0]       code;
      int unsigned      frame;
      int unsigned      w;
      int unsigned      b;
      bit               found;
      frame = 0;
      found = 1'b0;
      if (entry.entry_frame != '0) begin
         code = fba_pkg::STATUS_MAPPED;
      end else if (entry.kind == fba_pkg::KIND_ALLOC) begin
         w = 0;
         while (w < WORD_COUNT && used_words[w] == '1) w++;
         if (w < WORD_COUNT) begin
            b = 0;
            while (used_words[w][b]) b++;
            frame = w * fba_pkg::WORD_BITS + b;
            found = (frame < NUM_FRAMES);
         end
         if (found) begin
            claim_frame(frame);
            code = fba_pkg::STATUS_DONE;
         end else begin
            frame = 0;
            code  = fba_pkg::STATUS_NO_FREE;
         end
      end else begin
         frame = entry.phys_address / FRAME_BYTES;
         if (frame >= NUM_FRAMES) begin
            code = fba_pkg::STATUS_RANGE;
         end else begin
            claim_frame(frame);
            code = fba_pkg::STATUS_DONE;
         end
      end
      res.status       = code;
      res.frame_number = (code == fba_pkg::STATUS_DONE) ? 12'(frame) : 12'd0;
      res.present_bit  = (code == fba_pkg::STATUS_DONE);
      res.write_bit    = entry.writable_page;
      res.user_bit     = ~entry.kernel_page;
      return res;
   endfunction

   function automatic int field_mismatch(input string field, input int unsigned want,
                                         input int unsigned got);
      if (want == got) return 0;
      $error("%s: expected %0d, actual %0d", field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      fba_pkg::rsp_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         foreach (used_words[i]) used_words[i] = '0;
         used_total = 0;
         entry_results_q.delete();
      end else begin
         // compare before queuing, a result never comes in its own accept cycle
         if (rsp_strobe) begin
            if (entry_results_q.size() == 0) begin
               $error("result with no transaction outstanding, status %0d", rsp_data.status);
               errs++;
            end else begin
               want = entry_results_q.pop_front();
               errs += field_mismatch("status", want.status, rsp_data.status);
               errs += field_mismatch("frame_number", want.frame_number,
                                      rsp_data.frame_number);
               errs += field_mismatch("present_bit", want.present_bit, rsp_data.present_bit);
               errs += field_mismatch("write_bit", want.write_bit, rsp_data.write_bit);
               errs += field_mismatch("user_bit", want.user_bit, rsp_data.user_bit);
            end
         end
         if (start && !busy) entry_results_q.push_back(predict_page_entry(req_data));
      end
      mismatch_count    <= mismatch_count + errs;
      entries_in_flight <= entry_results_q.size();
      frames_free       <= NUM_FRAMES - used_total;
   end

endmodule

/* dv/frame_bitmap_allocator_tb.sv */
`timescale 1ns / 100ps
// top of the frame bitmap allocator bench: clock, reset and page entry stimulus
// depends on fba_pkg, frame_bitmap_allocator and frame_bitmap_allocator_checker
module frame_bitmap_allocator_tb;

   localparam int NUM_FRAMES  = 4096;
   localparam int FRAME_BYTES = 4096;

   // every dut input known from time zero
   logic             clock;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   fba_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   fba_pkg::rsp_type rsp_data;

   int mismatch_count;
   int entries_in_flight;
   int frames_free;

   // set while the sender must not idle between transactions
   bit steady_feed = 1'b0;

   // 20 ns period
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   frame_bitmap_allocator #(
      .NUM_FRAMES (NUM_FRAMES),
      .FRAME_BYTES(FRAME_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   // watches both channels and keeps the expected page entries
   frame_bitmap_allocator_checker #(
      .NUM_FRAMES (NUM_FRAMES),
      .FRAME_BYTES(FRAME_BYTES)
   ) entry_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .entries_in_flight(entries_in_flight),
      .frames_free      (frames_free)
   );

   function automatic fba_pkg::req_type page_entry(input logic kind, input logic [31:0] phys,
                                                   input logic [19:0] frame, input logic kern,
                                                   input logic wr);
      fba_pkg::req_type r;
      r.kind          = kind;
      r.phys_address  = phys;
      r.entry_frame   = frame;
      r.kernel_page   = kern;
      r.writable_page = wr;
      return r;
   endfunction

   // broad mix: both kinds, mostly empty entries, mostly in-range addresses
   function automatic fba_pkg::req_type mixed_entry();
      logic [31:0] phys;
      logic [19:0] frame;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         phys = $urandom_range(0, 32'h00FF_FFFF);
      end else if (pick < 85) begin
         phys = $urandom;
      end else begin
         // page and range boundaries
         case ($urandom_range(0, 5))
            0: phys = 32'h0000_0000;
            1: phys = 32'h0000_0FFF;
            2: phys = 32'h0000_1000;
            3: phys = 32'h00FF_FFFF;
            4: phys = 32'h0100_0000;
            default: phys = 32'hFFFF_FFFF;
         endcase
      end
      frame = ($urandom_range(0, 99) < 80) ? 20'd0 : 20'($urandom_range(1, 20'hF_FFFF));
      return page_entry($urandom_range(0, 1) ? fba_pkg::KIND_MAP : fba_pkg::KIND_ALLOC, phys,
                        frame, 1'($urandom), 1'($urandom));
   endfunction

   // filling traffic: mostly empty-entry allocates, some in-range maps, a little noise
   function automatic fba_pkg::req_type filling_entry();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85)
         return page_entry(fba_pkg::KIND_ALLOC, $urandom, 20'd0, 1'($urandom), 1'($urandom));
      if (pick < 95)
         return page_entry(fba_pkg::KIND_MAP, $urandom_range(0, 32'h00FF_FFFF), 20'd0,
                           1'($urandom), 1'($urandom));
      return mixed_entry();
   endfunction

   // one transaction: optional random idle, then hold start until accepted
   task automatic send_entry(input fba_pkg::req_type entry);
      int gap;
      if (!steady_feed && $urandom_range(0, 99) < 33) begin
         // long gaps land on the scan phase of a slow allocate
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= entry;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending until every outstanding transaction has its result
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (entries_in_flight != 0) @(posedge clock);
   endtask

   initial begin
      int fill_count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: frame zero first, then the special cases
      send_entry(page_entry(fba_pkg::KIND_ALLOC, 32'h0000_0000, 20'd0, 1'b1, 1'b0));
      send_entry(page_entry(fba_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 20'd0, 1'b0, 1'b1));
      // map of an already used frame
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'h0000_0000, 20'd0, 1'b1, 1'b1));
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'h0000_1FFF, 20'd0, 1'b0, 1'b0));
      // highest frame and the range edge
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'h00FF_FFFF, 20'd0, 1'b1, 1'b0));
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'h00FF_F000, 20'd0, 1'b0, 1'b1));
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'h0100_0000, 20'd0, 1'b0, 1'b1));
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'hFFFF_FFFF, 20'd0, 1'b1, 1'b1));
      // entry already holding a frame, for both kinds
      send_entry(page_entry(fba_pkg::KIND_ALLOC, 32'h0000_0000, 20'hF_FFFF, 1'b1, 1'b1));
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'hFFFF_FFFF, 20'd1, 1'b0, 1'b0));
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'h0000_3000, 20'h8_0000, 1'b1, 1'b0));
      // word boundary frames, then allocates past the hole at frame 2
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'h0001_F000, 20'd0, 1'b0, 1'b1));
      send_entry(page_entry(fba_pkg::KIND_MAP, 32'h0002_0000, 20'd0, 1'b1, 1'b0));
      send_entry(page_entry(fba_pkg::KIND_ALLOC, 32'h0000_0000, 20'd0, 1'b0, 1'b0));
      send_entry(page_entry(fba_pkg::KIND_ALLOC, 32'h1234_5678, 20'd0, 1'b1, 1'b1));
      send_entry(page_entry(fba_pkg::KIND_ALLOC, 32'h0000_0000, 20'd0, 1'b0, 1'b1));
      drain_results();

      // random mix with a stretch of back-to-back transactions
      for (int i = 0; i < 1200; i++) begin
         steady_feed = (i >= 400 && i < 700);
         if (i == 900) drain_results();
         send_entry(mixed_entry());
      end
      steady_feed = 1'b0;

      // allocation-heavy traffic so that later scans run over many full words
      fill_count = 0;
      while (frames_free != 0 && fill_count < 700) begin
         send_entry(filling_entry());
         fill_count++;
      end
      drain_results();

      // fuller bitmap: deep allocate scans mixed with maps
      for (int i = 0; i < 40; i++) send_entry(mixed_entry());
      send_entry(page_entry(fba_pkg::KIND_ALLOC, 32'h0000_0000, 20'd0, 1'b0, 1'b1));

      // let the last results arrive, then a margin for stray strobes
      drain_results();
      repeat (150) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #100_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
